FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL. Both macros compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/upd_pkg.sv
package upd_pkg;

    // Decoder phase: idle, after a percent sign, after a percent sign and one character.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_ONE  = 2'd2
    } phase_t;

    // One result word.
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } res_t;

    localparam int unsigned MAX_RES = 3;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] HEX_TEN  = 8'd10;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CH_0) && (c <= CH_9)) ||
               ((c >= CH_LA) && (c <= CH_LF)) ||
               ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    // Nibble value of a hex digit; only meaningful when is_hex() holds.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        if (c <= CH_9) begin
            d = c - CH_0;
        end else if (c >= CH_LA) begin
            d = c - CH_LA + HEX_TEN;
        end else begin
            d = c - CH_UA + HEX_TEN;
        end
        return d[3:0];
    endfunction

    // A plain character as it comes out: plus becomes space, the rest pass unchanged.
    function automatic res_t plain_res(input logic [7:0] c);
        res_t r;
        r.data  = (c == CH_PLUS) ? CH_SPACE : c;
        r.valid = 1'b1;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic res_t byte_res(input logic [7:0] b);
        res_t r;
        r.data  = b;
        r.valid = 1'b1;
        r.last  = 1'b0;
        return r;
    endfunction

endpackage

FILE: sv/url_percent_decoder.sv
// URL percent decoder (form-urlencoded): one character word in, zero to three byte words out.
// Each word passes through the input register and then the result buffer on its way to the output.
// Throughput: one input word per cycle while each character yields at most one result and
// m_tready holds; a failed escape with two or three results stalls the input while they drain.
// Reset (aresetn low, synchronous) empties both stages and returns the decoder to idle.
`include "assert_macros.svh"

module url_percent_decoder (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_char
    input  logic       s_tlast,    // in_last

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic       m_tuser,    // [0] out_valid: 0 marks a bare end-of-message word
    output logic       m_tlast     // last_out
);
    import upd_pkg::*;

    // ------------------------------------------------------------------
    // Input register. It takes a word whenever it is empty or is being
    // handed to the decoder in this cycle, so the input side can take one
    // more word while a finished result still waits at the output.
    // ------------------------------------------------------------------
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // Decoder state.
    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    // Result buffer: up to three words, slot 0 is presented on the output.
    res_t       slots_reg [MAX_RES];
    res_t       slots_next [MAX_RES];
    logic [1:0] cnt_reg, cnt_next;

    // Decoded results for the word in the input register.
    res_t       dec_res [MAX_RES];
    logic [1:0] dec_cnt;

    logic       hi_ok, lo_ok;
    logic       pop;
    logic       move;

    assign hi_ok = is_hex(held_reg);
    assign lo_ok = is_hex(in_char_reg);

    // The output side takes a word.
    assign pop  = (cnt_reg != 2'd0) && m_tready;
    // The held word is decoded once the buffer is empty after this cycle's pop.
    assign move = in_valid_reg && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready));

    assign s_tready = !in_valid_reg || move;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (move) begin
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Next phase and held character.
    // ------------------------------------------------------------------
    always_comb begin
        phase_next = phase_reg;
        held_next  = held_reg;
        if (move) begin
            unique case (phase_reg)
                PH_PCT: begin
                    held_next  = in_char_reg;
                    phase_next = PH_ONE;
                end
                PH_ONE: begin
                    if (hi_ok && lo_ok) begin
                        phase_next = PH_IDLE;
                    end else if (held_reg == CH_PCT) begin
                        // The held percent sign opens a new escape; the new character
                        // becomes its first digit.
                        held_next  = in_char_reg;
                        phase_next = PH_ONE;
                    end else if (in_char_reg == CH_PCT) begin
                        phase_next = PH_PCT;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = (in_char_reg == CH_PCT) ? PH_PCT : PH_IDLE;
                end
            endcase
            // End of message drops any escape still pending.
            if (in_last_reg) begin
                phase_next = PH_IDLE;
            end
        end
    end

    // ------------------------------------------------------------------
    // Results of the held word.
    // ------------------------------------------------------------------
    always_comb begin
        dec_cnt = 2'd0;
        for (int i = 0; i < MAX_RES; i++) begin
            dec_res[i] = '0;
        end
        unique case (phase_reg)
            PH_PCT: begin
                // First digit of an escape: nothing to emit yet.
            end
            PH_ONE: begin
                if (hi_ok && lo_ok) begin
                    dec_res[dec_cnt] = byte_res({hex_value(held_reg), hex_value(in_char_reg)});
                    dec_cnt = dec_cnt + 2'd1;
                end else begin
                    // Failed escape: a literal percent sign, then both held
                    // characters decoded again as fresh input.
                    dec_res[dec_cnt] = byte_res(CH_PCT);
                    dec_cnt = dec_cnt + 2'd1;
                    if (held_reg != CH_PCT) begin
                        dec_res[dec_cnt] = plain_res(held_reg);
                        dec_cnt = dec_cnt + 2'd1;
                        if (in_char_reg != CH_PCT) begin
                            dec_res[dec_cnt] = plain_res(in_char_reg);
                            dec_cnt = dec_cnt + 2'd1;
                        end
                    end
                end
            end
            default: begin
                if (in_char_reg != CH_PCT) begin
                    dec_res[dec_cnt] = plain_res(in_char_reg);
                    dec_cnt = dec_cnt + 2'd1;
                end
            end
        endcase
        if (in_last_reg) begin
            if (dec_cnt == 2'd0) begin
                // Nothing emitted: a bare end marker closes the message.
                dec_res[0].data  = '0;
                dec_res[0].valid = 1'b0;
                dec_res[0].last  = 1'b1;
                dec_cnt = 2'd1;
            end else begin
                dec_res[dec_cnt - 2'd1].last = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result buffer: loads a fresh set when the decoder moves, otherwise
    // shifts down by one word on every pop.
    // ------------------------------------------------------------------
    always_comb begin
        cnt_next = cnt_reg;
        for (int i = 0; i < MAX_RES; i++) begin
            slots_next[i] = slots_reg[i];
        end
        if (move) begin
            cnt_next = dec_cnt;
            for (int i = 0; i < MAX_RES; i++) begin
                slots_next[i] = dec_res[i];
            end
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
            for (int i = 0; i < MAX_RES - 1; i++) begin
                slots_next[i] = slots_reg[i + 1];
            end
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = slots_reg[0].data;
    assign m_tuser  = slots_reg[0].valid;
    assign m_tlast  = slots_reg[0].last;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
            phase_reg    <= PH_IDLE;
            held_reg     <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
            phase_reg    <= phase_next;
            held_reg     <= held_next;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        for (int i = 0; i < MAX_RES; i++) begin
            slots_reg[i] <= slots_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    // A message end always leaves the decoder idle.
    `ASSERT_NEXT(a_last_idle, aclk, aresetn, move && in_last_reg, phase_reg == PH_IDLE)
    // A bare end marker only ever appears as the closing word of a message.
    `ASSERT_IMPLY(a_bare_is_last, aclk, aresetn, m_tvalid && !m_tuser, m_tlast)
    // Only the final buffered word of a set can carry the end flag.
    `ASSERT_IMPLY(a_last_final, aclk, aresetn, cnt_reg > 2'd1, !slots_reg[0].last)
    // A decode never lands on a buffer that still holds words after this cycle.
    `ASSERT_IMPLY(a_move_empty, aclk, aresetn, move && (cnt_reg != 2'd0), pop)

endmodule
